/* src/pibht_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and defaults of the point-in-box hit table.
package pibht_pkg;

  localparam int unsigned MAX_BOXES_DEF = 64;

  // Configuration port: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_MAP_WIDTH  = 1'b0;
  localparam logic        REG_MAP_HEIGHT = 1'b1;
  localparam logic [14:0] MAP_WIDTH_RST  = 15'd1024;
  localparam logic [14:0] MAP_HEIGHT_RST = 15'd1024;

  typedef enum logic [2:0] {
    FN_QUERY  = 3'd0,
    FN_HCHECK = 3'd1,
    FN_VCHECK = 3'd2,
    FN_ADD    = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_MAP  = 2'd1,
    SRC_BOX  = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  // One stored box: corner, inclusive extent, player flag and owner.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic               player;
    logic [7:0]         owner;
  } box_t;

  typedef struct packed {
    logic       hit;
    src_e       source;
    logic       player;
    logic [7:0] owner;
    logic       full;
  } result_t;

endpackage

/* src/pibht_box_mem.sv */
`timescale 1ns / 1ps
// Box table memory: one write port, one registered read port.
module pibht_box_mem import pibht_pkg::*; #(
  parameter int unsigned DEPTH = MAX_BOXES_DEF
) (
  input  logic clk_i,
  input  logic wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  box_t wr_data_i,
  input  logic rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output box_t rd_data_o
);

  box_t mem [DEPTH];
  box_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/pibht_box_cmp.sv */
`timescale 1ns / 1ps
// Shared containment comparator: is the point inside one box, edges included.
module pibht_box_cmp import pibht_pkg::*; (
  input  logic signed [15:0] pt_x_i,
  input  logic signed [15:0] pt_y_i,
  input  box_t               box_i,
  output logic               inside_o
);

  logic signed [16:0] px, py, lx, ly, hx, hy;

  // 17 bits hold corner plus extent without wrap.
  assign px = {pt_x_i[15], pt_x_i};
  assign py = {pt_y_i[15], pt_y_i};
  assign lx = {box_i.x[15], box_i.x};
  assign ly = {box_i.y[15], box_i.y};
  assign hx = lx + $signed({2'b00, box_i.w});
  assign hy = ly + $signed({2'b00, box_i.h});

  assign inside_o = (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);

endmodule

/* src/point_in_box_hit_table.sv */
`timescale 1ns / 1ps
// Top level of the point-in-box hit table: sequencer, registers and output stage.
//
// Usage:
//   Requests enter on the input channel (in_valid_i / in_stall_o) with a
//   func code: point query, horizontal or vertical map-edge check, add box,
//   or clear. Every request produces exactly one result on the output
//   channel (out_valid_o / out_stall_i).
//   Checks, add, clear, unknown codes and off-map or empty-table queries go
//   from accept straight to the done state. A point query inside the map scans
//   stored boxes in insertion order through one shared comparator, one box per
//   cycle, fed by the single read port of the box memory, up to MAX_BOXES boxes.
//   in_stall_o is high while a request is in work. The result sits in an output
//   register; a new request is taken while an earlier result still waits, and a
//   finished result waits in the sequencer while the receiver stalls. Map width
//   and height are written over the APB-style port; the user must write them
//   only while idle, and the block itself does not enforce this. Reset empties
//   the table (box count zero, no clearing pass needed), sets both map extents
//   to 1024 and drops any pending result.
module point_in_box_hit_table import pibht_pkg::*; #(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              func_i,
  input  logic signed [15:0]      coord_x_i,
  input  logic signed [15:0]      coord_y_i,
  input  logic [14:0]             box_width_i,
  input  logic [14:0]             box_height_i,
  input  logic                    box_player_i,
  input  logic [7:0]              box_owner_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [1:0]              hit_source_o,
  output logic                    hit_player_o,
  output logic [7:0]              hit_owner_o,
  output logic                    table_full_o
);

  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

  // Outside test on one axis: negative, or at or beyond the extent.
  function automatic logic outside(input logic signed [15:0] c, input logic [14:0] ext);
    return c[15] || (c[14:0] >= ext);
  endfunction

  state_e             state_q, state_d;
  logic [14:0]        map_w_q, map_h_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   idx_next;
  logic signed [15:0] pt_x_q, pt_y_q;
  result_t            res_q, res_d;
  result_t            out_q;
  logic               out_valid_q, out_valid_d;

  logic               in_acc, out_free, cfg_wr;
  logic               ox, oy, tbl_full, tbl_empty, last, pt_in_box;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr;
  box_t               wr_box, rd_box;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= MAP_WIDTH_RST;
      map_h_q <= MAP_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAP_WIDTH:  map_w_q <= pwdata[14:0];
        REG_MAP_HEIGHT: map_h_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAP_WIDTH:  prdata = {17'd0, map_w_q};
      REG_MAP_HEIGHT: prdata = {17'd0, map_h_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- handshake and status ----------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign ox        = outside(coord_x_i, map_w_q);
  assign oy        = outside(coord_y_i, map_h_q);
  assign tbl_full  = (count_q == CNT_W'(MAX_BOXES));
  assign tbl_empty = (count_q == '0);
  assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);
  assign last      = (idx_next == count_q);

  // ---------------- box memory and comparator ----------------
  assign wr_box = '{x: coord_x_i, y: coord_y_i, w: box_width_i, h: box_height_i,
                    player: box_player_i, owner: box_owner_i};

  pibht_box_mem #(
    .DEPTH(MAX_BOXES)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (wr_box),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_box)
  );

  pibht_box_cmp u_cmp (
    .pt_x_i   (pt_x_q),
    .pt_y_i   (pt_y_q),
    .box_i    (rd_box),
    .inside_o (pt_in_box)
  );

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if ((func_e'(func_i) == FN_QUERY) && !ox && !oy && !tbl_empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (pt_in_box || last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    res_d   = res_q;
    count_d = count_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '{hit: 1'b0, source: SRC_NONE, player: 1'b0, owner: 8'd0, full: 1'b0};
          idx_d = '0;
          case (func_e'(func_i))
            FN_QUERY: begin
              if (ox || oy) begin
                res_d.hit    = 1'b1;
                res_d.source = SRC_MAP;
              end else begin
                rd_en = 1'b1;  // entry 0 lands for the first scan cycle
              end
            end
            FN_HCHECK: begin
              if (!oy && ox) begin
                res_d.hit    = 1'b1;
                res_d.source = SRC_MAP;
              end
            end
            FN_VCHECK: begin
              if (!ox && oy) begin
                res_d.hit    = 1'b1;
                res_d.source = SRC_MAP;
              end
            end
            FN_ADD: begin
              if (tbl_full) begin
                res_d.full = 1'b1;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            FN_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (pt_in_box) begin
          res_d.hit    = 1'b1;
          res_d.source = SRC_BOX;
          res_d.player = rd_box.player;
          res_d.owner  = rd_box.owner;
        end else if (!last) begin
          rd_en   = 1'b1;
          rd_addr = idx_next[IDX_W-1:0];
          idx_d   = idx_next[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register load.
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (in_acc) begin
      pt_x_q <= coord_x_i;
      pt_y_q <= coord_y_i;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_q.hit;
  assign hit_source_o = out_q.source;
  assign hit_player_o = out_q.player;
  assign hit_owner_o  = out_q.owner;
  assign table_full_o = out_q.full;

endmodule

/* verif/tb_point_in_box_hit_table.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the point-in-box hit table, with its own predictor.
module tb_point_in_box_hit_table;
  import pibht_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_BOXES_DEF;
  // Codes past the last defined func; the block must ignore them.
  localparam logic [2:0]  FN_BAD_FIRST = 3'd5;
  localparam logic [2:0]  FN_BAD_LAST  = 3'd7;
  localparam int unsigned MAX_REPORTS  = 10;

  // One request as the sender sees it: one member per payload port.
  typedef struct {
    logic [2:0]         func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic               player;
    logic [7:0]         owner;
  } hit_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            func_i = FN_QUERY;
  logic signed [15:0]    coord_x_i = '0;
  logic signed [15:0]    coord_y_i = '0;
  logic [14:0]           box_width_i = '0;
  logic [14:0]           box_height_i = '0;
  logic                  box_player_i = 1'b0;
  logic [7:0]            box_owner_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [1:0]            hit_source_o;
  logic                  hit_player_o;
  logic [7:0]            hit_owner_o;
  logic                  table_full_o;

  point_in_box_hit_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .box_player_i (box_player_i),
    .box_owner_i  (box_owner_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .hit_source_o (hit_source_o),
    .hit_player_o (hit_player_o),
    .hit_owner_o  (hit_owner_o),
    .table_full_o (table_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: map extents as last written, and the box table in
  // insertion order. Only entries below stored_boxes are ever looked at.
  // ---------------------------------------------------------------------------
  logic [14:0] map_w_cfg = MAP_WIDTH_RST;
  logic [14:0] map_h_cfg = MAP_HEIGHT_RST;
  int          tab_x   [TABLE_DEPTH];
  int          tab_y   [TABLE_DEPTH];
  int          tab_w   [TABLE_DEPTH];
  int          tab_h   [TABLE_DEPTH];
  logic        tab_pl  [TABLE_DEPTH];
  logic [7:0]  tab_own [TABLE_DEPTH];
  int unsigned stored_boxes = 0;

  hit_req_t    pending_reqs[$];   // requests not yet presented
  result_t     hit_report_q[$];   // predicted results, oldest first
  hit_req_t    gen_boxes[$];      // boxes the generator believes are stored

  int unsigned reqs_queued  = 0;
  int unsigned accepted     = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned box_hits     = 0;
  int unsigned map_hits     = 0;
  int unsigned dropped_adds = 0;
  int unsigned cfg_settings = 1;

  // Works out the result of one accepted request and updates the table.
  // All sums are taken as int, so a corner plus a 15-bit extent never wraps.
  function automatic result_t resolve_hit(hit_req_t r);
    result_t res;
    int      px;
    int      py;
    logic    off_x;
    logic    off_y;
    res   = '0;
    px    = int'(r.x);
    py    = int'(r.y);
    off_x = (px < 0) || (px >= int'(map_w_cfg));
    off_y = (py < 0) || (py >= int'(map_h_cfg));
    case (r.func)
      FN_QUERY: begin
        if (off_x || off_y) begin
          res.hit    = 1'b1;
          res.source = SRC_MAP;
          map_hits++;
        end else begin
          // first box in insertion order wins
          for (int i = 0; i < int'(stored_boxes) && !res.hit; i++) begin
            if (px >= tab_x[i] && px <= tab_x[i] + tab_w[i] &&
                py >= tab_y[i] && py <= tab_y[i] + tab_h[i]) begin
              res.hit    = 1'b1;
              res.source = SRC_BOX;
              res.player = tab_pl[i];
              res.owner  = tab_own[i];
              box_hits++;
            end
          end
        end
      end
      FN_HCHECK: begin
        if (!off_y && off_x) begin
          res.hit    = 1'b1;
          res.source = SRC_MAP;
          map_hits++;
        end
      end
      FN_VCHECK: begin
        if (!off_x && off_y) begin
          res.hit    = 1'b1;
          res.source = SRC_MAP;
          map_hits++;
        end
      end
      FN_ADD: begin
        if (stored_boxes >= TABLE_DEPTH) begin
          res.full = 1'b1;
          dropped_adds++;
        end else begin
          tab_x[stored_boxes]   = int'(r.x);
          tab_y[stored_boxes]   = int'(r.y);
          tab_w[stored_boxes]   = int'(r.w);
          tab_h[stored_boxes]   = int'(r.h);
          tab_pl[stored_boxes]  = r.player;
          tab_own[stored_boxes] = r.owner;
          stored_boxes++;
        end
      end
      FN_CLEAR: stored_boxes = 0;
      default: ;  // unknown codes change nothing
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation. The generator keeps its own view of the table so that
  // queries can be aimed at, on, and just beside stored boxes.
  // ---------------------------------------------------------------------------
  function automatic hit_req_t mk_req(logic [2:0] func, int x, int y, int w, int h,
                                      logic player, int owner);
    hit_req_t r;
    r.func   = func;
    r.x      = 16'(x);
    r.y      = 16'(y);
    r.w      = 15'(w);
    r.h      = 15'(h);
    r.player = player;
    r.owner  = 8'(owner);
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Coordinate on one axis: mostly inside the map, often on or just past an edge.
  function automatic logic signed [15:0] gen_coord(int extent);
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'(extent - 1);
      4: return 16'(extent);
      default: return (extent > 0) ? 16'($urandom_range(0, extent - 1)) : 16'($urandom);
    endcase
  endfunction

  // Box span: mostly small against the map so that boxes overlap.
  function automatic logic [14:0] gen_span(int extent);
    case ($urandom_range(0, 9))
      0: return 15'd0;
      1: return 15'($urandom);
      2: return 15'h7fff;
      default: return 15'($urandom_range(0, extent / 4 + 3));
    endcase
  endfunction

  // Point near the span [base, base+span]: the edges, one past them, or inside.
  function automatic logic signed [15:0] near_span(int base, int span);
    case ($urandom_range(0, 5))
      0: return clamp16(base);
      1: return clamp16(base + span);
      2: return clamp16(base - 1);
      3: return clamp16(base + span + 1);
      default: return clamp16(base + int'($urandom_range(0, span)));
    endcase
  endfunction

  function automatic hit_req_t gen_add();
    hit_req_t r;
    r = mk_req(FN_ADD, $urandom, $urandom, 0, 0, 1'($urandom), $urandom);
    if ($urandom_range(0, 9) != 0) begin
      r.x = gen_coord(int'(map_w_cfg));
      r.y = gen_coord(int'(map_h_cfg));
    end
    r.w = gen_span(int'(map_w_cfg));
    r.h = gen_span(int'(map_h_cfg));
    return r;
  endfunction

  function automatic hit_req_t gen_request();
    hit_req_t r;
    int       pick;
    int       k;
    // unused fields carry random noise on every request
    r    = mk_req(FN_QUERY, $urandom, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if (gen_boxes.size() != 0 && $urandom_range(0, 2) != 0) begin
        k   = $urandom_range(0, gen_boxes.size() - 1);
        r.x = near_span(int'(gen_boxes[k].x), int'(gen_boxes[k].w));
        r.y = near_span(int'(gen_boxes[k].y), int'(gen_boxes[k].h));
      end else if ($urandom_range(0, 4) != 0) begin
        r.x = gen_coord(int'(map_w_cfg));
        r.y = gen_coord(int'(map_h_cfg));
      end
    end else if (pick < 72) begin
      r = gen_add();
    end else if (pick < 92) begin
      r.func = (pick < 82) ? FN_HCHECK : FN_VCHECK;
      r.x    = gen_coord(int'(map_w_cfg));
      r.y    = gen_coord(int'(map_h_cfg));
    end else if (pick < 95) begin
      r.func = FN_CLEAR;
    end else begin
      r.func = 3'($urandom_range(FN_BAD_FIRST, FN_BAD_LAST));
    end
    return r;
  endfunction

  task automatic queue_req(hit_req_t r);
    if (r.func == FN_ADD && gen_boxes.size() < TABLE_DEPTH) gen_boxes = {gen_boxes, r};
    if (r.func == FN_CLEAR) gen_boxes.delete();
    pending_reqs = {pending_reqs, r};
    reqs_queued++;
  endtask

  // Waits until every queued request has come back as a result.
  task automatic wait_drained();
    while (results_seen < reqs_queued)
      @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready; the block is idle here.
  task automatic cfg_write(logic reg_sel, logic [14:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_MAP_WIDTH) map_w_cfg = value;
    else map_h_cfg = value;
  endtask

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Valid is registered and only drops after an accept, so a
  // stalled request holds still. Each request waits a randomly drawn gap, which
  // may be none; now and then a stretch of 64 requests goes back to back.
  // ---------------------------------------------------------------------------
  hit_req_t    cur_req;
  int unsigned gap_left = 0;
  logic        calm_in  = 1'b0;

  task automatic drive_req(hit_req_t r);
    cur_req = r;
    in_valid_i   <= 1'b1;
    func_i       <= r.func;
    coord_x_i    <= r.x;
    coord_y_i    <= r.y;
    box_width_i  <= r.w;
    box_height_i <= r.h;
    box_player_i <= r.player;
    box_owner_i  <= r.owner;
  endtask

  always @(posedge clk_i) begin : req_driver
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      // request accepted: predict now, in acceptance order
      hit_report_q = {hit_report_q, resolve_hit(cur_req)};
      accepted++;
      if (accepted % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
      gap = calm_in ? 0 : $urandom_range(0, 19);
      if (gap == 0 && pending_reqs.size() != 0) begin
        drive_req(pending_reqs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        gap_left   <= gap;
      end
    end else if (!in_valid_i) begin
      if (gap_left != 0) gap_left <= gap_left - 1;
      else if (pending_reqs.size() != 0) drive_req(pending_reqs.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. After each result the receiver draws a random stall, which
  // may be none, whether or not the next result is already up.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic        calm_out = 1'b0;

  always @(posedge clk_i) begin : result_monitor
    result_t     want;
    int unsigned stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (hit_report_q.size() == 0) begin
        flag_mismatch($sformatf("result with no request waiting: hit=%0b src=%0d pl=%0b own=%0d full=%0b",
                                hit_o, hit_source_o, hit_player_o, hit_owner_o, table_full_o));
      end else begin
        want = hit_report_q.pop_front();
        if (hit_o !== want.hit || hit_source_o !== want.source ||
            hit_player_o !== want.player || hit_owner_o !== want.owner ||
            table_full_o !== want.full)
          flag_mismatch($sformatf({"result %0d: expected hit=%0b src=%0d pl=%0b own=%0d full=%0b,",
                                   " got hit=%0b src=%0d pl=%0b own=%0d full=%0b"},
                                  results_seen, want.hit, want.source, want.player, want.owner,
                                  want.full, hit_o, hit_source_o, hit_player_o, hit_owner_o,
                                  table_full_o));
      end
      results_seen++;
      if (results_seen % 64 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall       = calm_out ? 0 : $urandom_range(0, 19);
      stall_left  <= stall;
      out_stall_i <= (stall != 0);
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed requests under the reset map, then random phases, each
  // behind a new map setting written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [14:0] nw;
    logic [14:0] nh;
    int          n_items;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, boundary hits on every side and the coordinate extremes
    queue_req(mk_req(FN_QUERY, 0, 0, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_QUERY, -1, 0, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_QUERY, MAP_WIDTH_RST, 5, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_QUERY, 5, -32768, 32767, 32767, 1'b1, 255));
    queue_req(mk_req(FN_QUERY, 32767, 32767, 0, 0, 1'b0, 0));
    // edge checks: hit only across the tested edge with the other axis inside
    queue_req(mk_req(FN_HCHECK, -1, 10, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_HCHECK, MAP_WIDTH_RST, MAP_HEIGHT_RST - 1, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_HCHECK, -5, -5, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_HCHECK, 10, 10, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_VCHECK, 10, -1, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_VCHECK, MAP_WIDTH_RST - 1, MAP_HEIGHT_RST, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_VCHECK, -1, -1, 0, 0, 1'b0, 0));
    // single-point box, overlapping box, extreme corner with extreme span
    queue_req(mk_req(FN_ADD, 10, 10, 0, 0, 1'b1, 255));
    queue_req(mk_req(FN_ADD, 5, 5, 20, 20, 1'b0, 8'h5a));
    queue_req(mk_req(FN_ADD, -32768, -32768, 32767, 32767, 1'b1, 8'h81));
    queue_req(mk_req(FN_ADD, 1000, 1000, 32767, 32767, 1'b0, 8'h3c));
    queue_req(mk_req(FN_QUERY, 10, 10, 0, 0, 1'b0, 0));      // first box wins the overlap
    queue_req(mk_req(FN_QUERY, 25, 25, 0, 0, 1'b0, 0));      // far corner, edge included
    queue_req(mk_req(FN_QUERY, 26, 26, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_QUERY, 1023, 1023, 0, 0, 1'b0, 0));  // sum past 16 bits
    for (int f = FN_BAD_FIRST; f <= FN_BAD_LAST; f++)
      queue_req(mk_req(3'(f), 7, 7, 1, 1, 1'b1, 1));
    queue_req(mk_req(FN_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    queue_req(mk_req(FN_QUERY, 10, 10, 0, 0, 1'b0, 0));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nw = 15'd1;     nh = 15'd1;     end
        1: begin nw = 15'h7fff;  nh = 15'h7fff;  end
        2: begin nw = 15'd0;     nh = 15'd300;   end  // every x outside the map
        3: begin nw = 15'd300;   nh = 15'd0;     end  // every y outside the map
        4: begin nw = 15'd64;    nh = 15'd48;    end
        5: begin nw = 15'($urandom_range(1, 200));   nh = 15'($urandom_range(1, 200));   end
        6: begin nw = 15'($urandom_range(1, 32767)); nh = 15'($urandom_range(1, 32767)); end
        default: begin nw = MAP_WIDTH_RST; nh = MAP_HEIGHT_RST; end
      endcase
      cfg_write(REG_MAP_WIDTH, nw);
      cfg_write(REG_MAP_HEIGHT, nh);
      cfg_settings++;
      n_items = (ph == 2 || ph == 3) ? 40 : 115;
      if (ph % 3 == 1) begin
        // fill the table past capacity, then query into a full table
        queue_req(mk_req(FN_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0, 0));
        for (int i = 0; i < TABLE_DEPTH + 2; i++) queue_req(gen_add());
        n_items = n_items - TABLE_DEPTH - 3;
      end
      for (int i = 0; i < n_items; i++) queue_req(gen_request());
      wait_drained();
    end

    // a late spurious result would still be caught here
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);
    $display("%0d requests under %0d map settings; %0d box hits, %0d map hits, %0d adds dropped",
             accepted, cfg_settings, box_hits, map_hits, dropped_adds);
    $display("%0d results checked, %0d mismatching", results_seen, mismatches);
    if (mismatches == 0 && hit_report_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Slowest legal run is under a tenth of this.
  initial begin : watchdog
    #9_000_000;
    $display("Timeout: %0d requests still queued, %0d results outstanding",
             pending_reqs.size(), hit_report_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* point_in_box_hit_table.f */
src/pibht_pkg.sv
src/pibht_box_mem.sv
src/pibht_box_cmp.sv
src/point_in_box_hit_table.sv
verif/tb_point_in_box_hit_table.sv
